[rtl/core/bu2x_pkg.sv]
// ============================================================================
// bu2x_pkg
// Shared constants, types and helper functions for the 2x bilinear upscaler.
// ============================================================================
package bu2x_pkg;

    // Source image limits
    localparam int MAX_SRC_WIDTH  = 32;
    localparam int MAX_SRC_HEIGHT = 32;
    localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

    // Field widths fixed by the interface
    localparam int CFG_W    = 6;    // active_width / active_height registers
    localparam int CFG_IDX_W = 1;   // two registers
    localparam int PIX_W    = 8;
    localparam int COORD_W  = 6;    // out_row / out_col
    localparam int VALUE_W  = 10;   // result, quarter units

    // Derived widths
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int ROW_W   = $clog2(MAX_SRC_HEIGHT);
    localparam int COL_W   = $clog2(MAX_SRC_WIDTH);
    localparam int DIM_W   = $clog2(((MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                                     MAX_SRC_WIDTH : MAX_SRC_HEIGHT) + 1);
    localparam int TOTAL_W = 2 * DIM_W;

    // Neighbour taps: bit 1 selects the lower row, bit 0 the right column
    localparam int NUM_TAPS = 4;
    localparam int TAP_W    = $clog2(NUM_TAPS);
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);

    // Codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } bu2x_state_t;

    typedef struct packed {
        logic             load_en;   // write incoming pixel to the store
        logic             start;     // latch coordinates, clear accumulator
        logic             rd_en;     // issue a store read for tap
        logic [TAP_W-1:0] tap;
        logic             out_load;  // move accumulator to output register
    } bu2x_cmd_t;

    typedef struct packed {
        logic out_free;              // output register can take a result
    } bu2x_stat_t;

    // Register value to effective size: 0 acts as 1, large values saturate
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > maxv)
            r = DIM_W'(maxv);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    // Source index saturated at size-1; also applied to the following neighbour
    function automatic int clamp_idx(input int idx, input logic [DIM_W-1:0] size);
        int lim;
        lim = int'(size) - 1;
        return (idx > lim) ? lim : idx;
    endfunction

endpackage

[rtl/core/bu2x_ram.sv]
// ============================================================================
// bu2x_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module bu2x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/bu2x_ctrl.sv]
// ============================================================================
// bu2x_ctrl
// Sequencer: accepts transactions, steps the four neighbour reads, hands off.
// ============================================================================
module bu2x_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   action,
    input  bu2x_pkg::bu2x_stat_t   stat,
    output bu2x_pkg::bu2x_cmd_t    cmd
);
    import bu2x_pkg::*;

    bu2x_state_t      state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        tap_next   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && action == ACT_COMPUTE)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                tap_next = tap_reg + TAP_W'(1);
                if (tap_reg == LAST_TAP)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready     = 1'b0;
        cmd.load_en  = 1'b0;
        cmd.start    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.tap      = tap_reg;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_en = s_tvalid && action == ACT_LOAD;
                cmd.start   = s_tvalid && action == ACT_COMPUTE;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.rd_en = 1'b0;
            end
            ST_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/bu2x_dp.sv]
// ============================================================================
// bu2x_dp
// Datapath: size registers, load counter, image store, blend accumulator and
// output register.
// ============================================================================
module bu2x_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bu2x_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bu2x_pkg::CFG_W-1:0]      cfg_data,
    input  logic [bu2x_pkg::PIX_W-1:0]      pixel_in,
    input  logic [bu2x_pkg::COORD_W-1:0]    out_row,
    input  logic [bu2x_pkg::COORD_W-1:0]    out_col,
    input  bu2x_pkg::bu2x_cmd_t             cmd,
    output bu2x_pkg::bu2x_stat_t            stat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bu2x_pkg::VALUE_W-1:0]    value
);
    import bu2x_pkg::*;

    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [ADDR_W-1:0]  load_addr_reg, load_addr_next;
    logic [ROW_W-1:0]   r0_reg, r1_reg;
    logic [COL_W-1:0]   c0_reg, c1_reg;
    logic               fy_reg, fx_reg;
    logic               rd_d_reg;
    logic [TAP_W-1:0]   tap_d_reg;
    logic               oob_d_reg;
    logic [VALUE_W-1:0] acc_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_data_reg;

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] wr_addr_ext, wr_addr_inc;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ROW_W-1:0]   r0_in, r1_in, rd_row;
    logic [COL_W-1:0]   c0_in, c1_in, rd_col;
    logic [ROW_W+CFG_W-1:0] row_base;
    logic [ROW_W+CFG_W-1:0] rd_index;
    logic               rd_oob;
    logic [ADDR_W-1:0]  rd_addr;
    logic [PIX_W-1:0]   rd_data;
    logic [PIX_W-1:0]   pix;
    logic [1:0]         wy, wx;
    logic [2:0]         wprod;
    logic [VALUE_W-1:0] term;

    assign w_eff = clamp_dim(width_reg, MAX_SRC_WIDTH);
    assign h_eff = clamp_dim(height_reg, MAX_SRC_HEIGHT);
    assign total = w_eff * h_eff;

    // load address wraps at the end of the active frame
    assign wr_addr_ext    = (TOTAL_W'(load_addr_reg) >= total) ? '0
                                                               : TOTAL_W'(load_addr_reg);
    assign wr_addr        = wr_addr_ext[ADDR_W-1:0];
    assign wr_addr_inc    = wr_addr_ext + TOTAL_W'(1);
    assign load_addr_next = (wr_addr_inc >= total) ? '0 : wr_addr_inc[ADDR_W-1:0];

    // source neighbours, saturated at the last row and column
    assign r0_in = ROW_W'(clamp_idx(int'(out_row[COORD_W-1:1]), h_eff));
    assign r1_in = ROW_W'(clamp_idx(int'(r0_in) + 1, h_eff));
    assign c0_in = COL_W'(clamp_idx(int'(out_col[COORD_W-1:1]), w_eff));
    assign c1_in = COL_W'(clamp_idx(int'(c0_in) + 1, w_eff));

    // row stride is the raw width register; an index past the store reads zero
    assign rd_row   = cmd.tap[1] ? r1_reg : r0_reg;
    assign rd_col   = cmd.tap[0] ? c1_reg : c0_reg;
    assign row_base = rd_row * width_reg;
    assign rd_index = row_base + (ROW_W+CFG_W)'(rd_col);
    assign rd_oob   = (rd_index >= (ROW_W+CFG_W)'(STORE_DEPTH));
    assign rd_addr  = ADDR_W'(rd_index);

    bu2x_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_en),
        .waddr (wr_addr),
        .wdata (pixel_in),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign pix = oob_d_reg ? '0 : rd_data;

    // weights in halves: near 2-f, far f
    assign wy    = tap_d_reg[1] ? {1'b0, fy_reg} : (2'd2 - {1'b0, fy_reg});
    assign wx    = tap_d_reg[0] ? {1'b0, fx_reg} : (2'd2 - {1'b0, fx_reg});
    assign wprod = {1'b0, wy} * {1'b0, wx};
    assign term  = VALUE_W'(pix) * VALUE_W'(wprod);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= CFG_RESET;
            height_reg    <= CFG_RESET;
            load_addr_reg <= '0;
            rd_d_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ACTIVE_WIDTH:  width_reg  <= cfg_data;
                    REG_ACTIVE_HEIGHT: height_reg <= cfg_data;
                    default:           width_reg  <= width_reg;
                endcase
                load_addr_reg <= '0;
            end
            else if (cmd.load_en)
            begin
                load_addr_reg <= load_addr_next;
            end

            rd_d_reg <= cmd.rd_en;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tap_d_reg <= cmd.tap;
        oob_d_reg <= rd_oob;
        if (cmd.start)
        begin
            r0_reg  <= r0_in;
            r1_reg  <= r1_in;
            c0_reg  <= c0_in;
            c1_reg  <= c1_in;
            fy_reg  <= out_row[0];
            fx_reg  <= out_col[0];
            acc_reg <= '0;
        end
        else if (rd_d_reg)
        begin
            acc_reg <= acc_reg + term;
        end
        if (cmd.out_load)
            out_data_reg <= acc_reg;
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign value         = out_data_reg;

endmodule

[rtl/core/bilinear_upscale_2x_unit.sv]
// ============================================================================
// bilinear_upscale_2x_unit
// Holds a small source image and returns 2x bilinear-upscaled pixels on demand.
// ============================================================================
// Usage:
//   Slave stream (s_*): s_tuser[0] is the action. A load transaction (0)
//   writes s_tdata pixel_in to the next raster position of the source image;
//   a compute transaction (1) names output pixel (out_row, out_col) of the
//   twice-size image. Master stream (m_*) carries one result per compute:
//   the blend of the four neighbours, times four (two fraction bits).
//   Config port: cfg_we with cfg_index 0 = active_width, 1 = active_height.
//   Write only while idle; any write restarts loading at the top-left pixel.
// Timing:
//   A compute reads its four neighbours one per cycle from the single read
//   port of the image store, then m_tvalid rises once the output register
//   takes the blend, and the next transaction is taken in the same cycle.
// Reset: sizes return to 32x32, load position to zero, no pending result.
//   Store contents are undefined until loaded.
// Stall: a result held in the output register while m_tready is low does
//   not block loads; a following compute waits at its hand-off until the
//   output register frees up.
// ============================================================================
module bilinear_upscale_2x_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // pixel_in, out_row, out_col, pad
    input  logic [0:0]                     s_tuser,   // action
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // value, pad
    // configuration
    input  logic                           cfg_we,
    input  logic [bu2x_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bu2x_pkg::CFG_W-1:0]     cfg_data
);
    import bu2x_pkg::*;

    bu2x_cmd_t          cmd;
    bu2x_stat_t         stat;
    logic [VALUE_W-1:0] value;

    // sequencer owns the input handshake
    bu2x_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser[0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath owns the store and the output register
    bu2x_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (s_tdata[PIX_W-1:0]),
        .out_row   (s_tdata[PIX_W+COORD_W-1:PIX_W]),
        .out_col   (s_tdata[PIX_W+2*COORD_W-1:PIX_W+COORD_W]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .value     (value)
    );

    assign m_tdata = {(16 - VALUE_W)'(0), value};

endmodule
